### sv/rle_nibble_unpacker_defines.svh
// assertion macros shared by the rtl
`ifndef RLE_NIBBLE_UNPACKER_DEFINES_SVH
`define RLE_NIBBLE_UNPACKER_DEFINES_SVH

// same-cycle implication, checked on every rising clk outside reset
`define RNU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RNU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rnu_pkg.sv
`timescale 1ns / 1ps

package rnu_pkg;

    localparam logic [3:0] NIB_MASK  = 4'hF;
    localparam logic [2:0] GROUP_END = 3'd7;

    typedef enum logic [2:0]
    {
        PH_HDR_HI = 3'b001,
        PH_HDR_LO = 3'b010,
        PH_RUNS   = 3'b100
    } phase_t;

    typedef struct packed
    {
        phase_t      phase;
        logic [15:0] blocks_left;
        logic [31:0] acc;
        logic [2:0]  pixels_needed;
    } state_t;

    typedef struct packed
    {
        logic [1:0]  count;
        logic [31:0] word0;
        logic [31:0] word1;
    } result_t;

    // ones in the low n nibbles, n from 0 to 8; any larger n gives all ones
    function automatic logic [31:0] nib_mask(input logic [4:0] n);
        logic [31:0] m;
        begin
            if (n >= 5'd8)
            begin
                m = '1;
            end
            else
            begin
                m = ~(32'hFFFF_FFFF << {n[2:0], 2'b00});
            end
            return m;
        end
    endfunction

endpackage

### sv/rle_nibble_unpacker.sv
`timescale 1ns / 1ps

// 4-bit run-length decoder. Each stream byte is taken into an input register and
// decoded from there, once the output buffer has room, into zero, one or two 32-bit
// pixel words, which go into a two-word output buffer; the next byte may be accepted
// in the same cycle as that decode. The single output port moves one word a cycle
// while m_tready is high, so a byte that completes two words holds off the decode of
// the next byte until the first of them is taken. The first pixel of a word sits in
// the top nibble; m_tlast marks the last word caused by a byte. After the last run
// block of a stream, a partial word is dropped and a new header is expected.

`include "rle_nibble_unpacker_defines.svh"

module rle_nibble_unpacker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // word_out
    output logic        m_tlast     // last_in_run
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    rnu_pkg::state_t   state_reg;
    rnu_pkg::state_t   state_next;
    rnu_pkg::result_t  res;
    logic [1:0]        out_cnt_reg;
    logic [1:0]        out_cnt_next;
    logic [31:0]       slot0_reg;
    logic [31:0]       slot0_next;
    logic              slot0_last_reg;
    logic              slot0_last_next;
    logic [31:0]       slot1_reg;
    logic [31:0]       slot1_next;
    logic              proc;
    logic              pop;

    rnu_step u_step
    (
        .in_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res)
    );

    assign pop      = (out_cnt_reg != 2'd0) && m_tready;
    assign proc     = in_valid_reg &&
                      ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_tready));
    assign s_tready = !in_valid_reg || proc;

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg;
    assign m_tlast  = slot0_last_reg;

    always_comb
    begin
        out_cnt_next    = out_cnt_reg;
        slot0_next      = slot0_reg;
        slot0_last_next = slot0_last_reg;
        slot1_next      = slot1_reg;
        if (proc)
        begin
            out_cnt_next    = res.count;
            slot0_next      = res.word0;
            slot0_last_next = (res.count == 2'd1);
            slot1_next      = res.word1;
        end
        else if (pop)
        begin
            out_cnt_next    = out_cnt_reg - 2'd1;
            slot0_next      = slot1_reg;
            slot0_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_cnt_reg             <= 2'd0;
            state_reg.phase         <= rnu_pkg::PH_HDR_HI;
            state_reg.blocks_left   <= '0;
            state_reg.acc           <= '0;
            state_reg.pixels_needed <= rnu_pkg::GROUP_END;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (proc)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        slot0_reg      <= slot0_next;
        slot0_last_reg <= slot0_last_next;
        slot1_reg      <= slot1_next;
    end

    `RNU_ASSERT_IMPL(a_cnt_range, 1'b1, out_cnt_reg != 2'd3, "output count out of range")
    `RNU_ASSERT_IMPL(a_proc_room, proc, (out_cnt_reg == 2'd0) || pop, "decode without buffer room")
    `RNU_ASSERT_NEXT(a_two_words, proc && (res.count == 2'd2),
                     (out_cnt_reg == 2'd2) && !slot0_last_reg, "pair of words not buffered")
    `RNU_ASSERT_NEXT(a_end_clear, proc && (state_next.phase == rnu_pkg::PH_HDR_HI),
                     (state_reg.acc == 32'd0) && (state_reg.pixels_needed == rnu_pkg::GROUP_END),
                     "word not cleared at end of stream")
    `RNU_ASSERT_NEXT(a_in_hold, in_valid_reg && !proc,
                     in_valid_reg && $stable(in_byte_reg), "pending byte lost")

endmodule

### sv/rnu_step.sv
`timescale 1ns / 1ps

module rnu_step
(
    input  logic [7:0]       in_byte,
    input  rnu_pkg::state_t  cur,
    output rnu_pkg::state_t  nxt,
    output rnu_pkg::result_t res
);

    logic [3:0]  pix;
    logic [4:0]  len;
    logic [4:0]  first_need;
    logic [31:0] rep;
    logic [6:0]  acc_shamt;
    logic [5:0]  word_shamt;
    logic        got_first;
    logic        got_second;
    logic [15:0] blocks_dec;
    logic [15:0] hdr_count;

    assign pix        = in_byte[3:0] & rnu_pkg::NIB_MASK;
    assign len        = {1'b0, in_byte[7:4]} + 5'd1;
    assign first_need = {2'b00, cur.pixels_needed} + 5'd1;
    assign rep        = {8{pix}};
    assign acc_shamt  = {len, 2'b00};
    assign word_shamt = {first_need[3:0], 2'b00};
    assign got_first  = (len >= first_need);
    assign got_second = ({1'b0, len} >= ({1'b0, first_need} + 6'd8));
    assign blocks_dec = cur.blocks_left - 16'd1;
    assign hdr_count  = {cur.blocks_left[7:0], in_byte};

    always_comb
    begin
        nxt       = cur;
        res.count = 2'd0;
        res.word0 = (cur.acc << word_shamt) | (rep & rnu_pkg::nib_mask(first_need));
        res.word1 = rep;
        case (cur.phase)
            rnu_pkg::PH_HDR_LO:
            begin
                nxt.blocks_left   = hdr_count;
                nxt.acc           = '0;
                nxt.pixels_needed = rnu_pkg::GROUP_END;
                nxt.phase         = (hdr_count == 16'd0) ? rnu_pkg::PH_HDR_HI
                                                         : rnu_pkg::PH_RUNS;
            end
            rnu_pkg::PH_RUNS:
            begin
                res.count         = {1'b0, got_first} + {1'b0, got_second};
                nxt.acc           = (cur.acc << acc_shamt) | (rep & rnu_pkg::nib_mask(len));
                nxt.pixels_needed = cur.pixels_needed - len[2:0];
                nxt.blocks_left   = blocks_dec;
                if (blocks_dec == 16'd0)
                begin
                    nxt.phase         = rnu_pkg::PH_HDR_HI;
                    nxt.acc           = '0;
                    nxt.pixels_needed = rnu_pkg::GROUP_END;
                end
            end
            default:
            begin
                nxt.blocks_left = {8'h00, in_byte};
                nxt.phase       = rnu_pkg::PH_HDR_LO;
            end
        endcase
    end

endmodule
